// ----- sv/slr_pkg.sv -----
// ----------------------------------------------------------------------------
// slr_pkg: shared types and constants of the scaled line rasteriser
// Register map, item kinds, the control word passed from front end to walker,
// and the fixed widths of the stream fields.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;  // screen coordinate width
  localparam int unsigned FIELD_W        = 16;  // projected and pixel fields
  localparam int unsigned ZOOM_W         = 16;
  localparam int unsigned COLOR_W        = 24;
  localparam int unsigned FRAC_BITS      = 12;  // Q12.4 times Q8.8
  localparam int unsigned CFG_ADDR_W     = 4;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned FRONT_STAGES   = 5;
  localparam int unsigned QUEUE_DEPTH    = 8;

  localparam logic [ZOOM_W-1:0] ZOOM_RESET = 16'd256;

  typedef enum logic [1:0] {
    REG_ZOOM    = 2'd0,
    REG_SHIFT_X = 2'd1,
    REG_SHIFT_Y = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_e;

  typedef struct packed {
    logic [ZOOM_W-1:0]         zoom;
    logic signed [FIELD_W-1:0] shift_x;
    logic signed [FIELD_W-1:0] shift_y;
  } cfg_t;

  typedef struct packed {
    logic is_start;    // start item, otherwise advance
    logic drawable;    // endpoints differ
    logic major_is_x;
    logic step_down;   // minor axis walks downwards
  } item_ctl_t;

endpackage

// ----- sv/scaled_line_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// scaled_line_rasterizer_top: scaled Bresenham line rasteriser
// Start items project two endpoints to screen space; advance items step the
// line one pixel at a time.
// ----------------------------------------------------------------------------
// One item is taken per clock while the input has credit, and at most one
// pixel is produced per clock. An item passes through the set-up pipeline
// (zoom multiply, truncation, shift and saturation, axis ordering, error
// terms), then waits in an eight-entry queue for the walker, which handles
// one item per cycle while its output register is empty or being taken, and
// places its pixel in the output register. The input side accepts while
// fewer than eight items are in flight between the input and the walker, so
// output stalls are absorbed without bubbles. A start item whose endpoints
// land on the same screen pixel produces nothing; an advance with no active
// line produces nothing. Registers should be written only while the block is
// idle.
// ----------------------------------------------------------------------------
module scaled_line_rasterizer_top #(
  parameter int unsigned COORD_BITS = slr_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // from_x, from_y, to_x, to_y, color
  input  logic        s_axis_tuser,   // action
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // pixel_x, pixel_y, pixel_color
  output logic        m_axis_tlast,   // last_pixel
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned W       = COORD_BITS;
  localparam int unsigned CW      = slr_pkg::COLOR_W;
  localparam int unsigned ENTRY_W = $bits(slr_pkg::item_ctl_t) + 2*W + (W+1) + 3*(W+3) + CW;

  slr_pkg::cfg_t cfg;

  logic                  push, pop, q_valid;
  slr_pkg::item_ctl_t    f_ctl, b_ctl;
  logic signed [W-1:0]   f_x0, f_y0, b_x0, b_y0;
  logic [W:0]            f_maj, b_maj;
  logic signed [W+2:0]   f_err0, f_incp, f_incn, b_err0, b_incp, b_incn;
  logic [CW-1:0]         f_color, b_color;
  logic [ENTRY_W-1:0]    q_wdata, q_rdata;
  logic [15:0]           px, py;
  logic [CW-1:0]         pcol;

  assign pready = 1'b1;

  slr_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  slr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_action_i   (s_axis_tuser),
    .in_from_x_i   (s_axis_tdata[15:0]),
    .in_from_y_i   (s_axis_tdata[31:16]),
    .in_to_x_i     (s_axis_tdata[47:32]),
    .in_to_y_i     (s_axis_tdata[63:48]),
    .in_color_i    (s_axis_tdata[87:64]),
    .pop_i         (pop),
    .push_o        (push),
    .ctl_o         (f_ctl),
    .x0_o          (f_x0),
    .y0_o          (f_y0),
    .major_delta_o (f_maj),
    .err0_o        (f_err0),
    .inc_pos_o     (f_incp),
    .inc_neg_o     (f_incn),
    .color_o       (f_color)
  );

  assign q_wdata = {f_ctl, f_x0, f_y0, f_maj, f_err0, f_incp, f_incn, f_color};

  slr_queue #(.WIDTH(ENTRY_W), .DEPTH(slr_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign {b_ctl, b_x0, b_y0, b_maj, b_err0, b_incp, b_incn, b_color} = q_rdata;

  slr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_ctl_i         (b_ctl),
    .q_x0_i          (b_x0),
    .q_y0_i          (b_y0),
    .q_major_delta_i (b_maj),
    .q_err0_i        (b_err0),
    .q_inc_pos_i     (b_incp),
    .q_inc_neg_i     (b_incn),
    .q_color_i       (b_color),
    .q_pop_o         (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_x_o         (px),
    .out_y_o         (py),
    .out_color_o     (pcol),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {pcol, py, px};

endmodule

// ----- sv/slr_regs.sv -----
// ----------------------------------------------------------------------------
// slr_regs: configuration registers
// APB-style register file holding zoom and the two screen shifts.
// ----------------------------------------------------------------------------
module slr_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [slr_pkg::CFG_ADDR_W-1:0]    paddr_i,
  input  logic [slr_pkg::CFG_DATA_W-1:0]    pwdata_i,
  output logic [slr_pkg::CFG_DATA_W-1:0]    prdata_o,
  output slr_pkg::cfg_t                     cfg_o
);

  localparam int unsigned DW = slr_pkg::CFG_DATA_W;
  localparam int unsigned FW = slr_pkg::FIELD_W;

  slr_pkg::cfg_t    cfg_q, cfg_d;
  slr_pkg::reg_idx_e idx;
  logic             wr_en;

  // pready is tied high, so the access phase always completes
  assign wr_en = psel_i & penable_i & pwrite_i;
  assign idx   = slr_pkg::reg_idx_e'(paddr_i[slr_pkg::CFG_ADDR_W-1:2]);

  always_comb begin
    cfg_d    = cfg_q;
    prdata_o = '0;
    case (idx)
      slr_pkg::REG_ZOOM: begin
        prdata_o = DW'(cfg_q.zoom);
        if (wr_en) cfg_d.zoom = pwdata_i[slr_pkg::ZOOM_W-1:0];
      end
      slr_pkg::REG_SHIFT_X: begin
        prdata_o = DW'(unsigned'(cfg_q.shift_x));
        if (wr_en) cfg_d.shift_x = pwdata_i[FW-1:0];
      end
      slr_pkg::REG_SHIFT_Y: begin
        prdata_o = DW'(unsigned'(cfg_q.shift_y));
        if (wr_en) cfg_d.shift_y = pwdata_i[FW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom    <= slr_pkg::ZOOM_RESET;
      cfg_q.shift_x <= '0;
      cfg_q.shift_y <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/slr_queue.sv -----
// ----------------------------------------------------------------------------
// slr_queue: decoupling queue
// Small register FIFO between the front end and the walker. The front end's
// credit counter guarantees it never overflows.
// ----------------------------------------------------------------------------
module slr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = slr_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

// ----- sv/slr_front.sv -----
// ----------------------------------------------------------------------------
// slr_front: input pipeline
// Five-stage pipeline: zoom products, truncation toward zero, shift and
// saturation, axis selection and ordering, Bresenham set-up terms.
// Advance items ride through unchanged. Input flow is credit based.
// ----------------------------------------------------------------------------
module slr_front #(
  parameter int unsigned COORD_BITS = slr_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  slr_pkg::cfg_t                       cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_action_i,
  input  logic signed [slr_pkg::FIELD_W-1:0]  in_from_x_i,
  input  logic signed [slr_pkg::FIELD_W-1:0]  in_from_y_i,
  input  logic signed [slr_pkg::FIELD_W-1:0]  in_to_x_i,
  input  logic signed [slr_pkg::FIELD_W-1:0]  in_to_y_i,
  input  logic [slr_pkg::COLOR_W-1:0]         in_color_i,
  input  logic                                pop_i,
  output logic                                push_o,
  output slr_pkg::item_ctl_t                  ctl_o,
  output logic signed [COORD_BITS-1:0]        x0_o,
  output logic signed [COORD_BITS-1:0]        y0_o,
  output logic [COORD_BITS:0]                 major_delta_o,
  output logic signed [COORD_BITS+2:0]        err0_o,
  output logic signed [COORD_BITS+2:0]        inc_pos_o,
  output logic signed [COORD_BITS+2:0]        inc_neg_o,
  output logic [slr_pkg::COLOR_W-1:0]         color_o
);

  localparam int unsigned W       = COORD_BITS;
  localparam int unsigned FW      = slr_pkg::FIELD_W;
  localparam int unsigned FB      = slr_pkg::FRAC_BITS;
  localparam int unsigned PROD_W  = FW + slr_pkg::ZOOM_W + 1;
  localparam int unsigned TRUNC_W = PROD_W - FB;
  localparam int unsigned SUM_W   = (TRUNC_W + 1 > W + 1) ? TRUNC_W + 1 : W + 1;
  localparam int unsigned ERR_W   = W + 3;
  localparam int unsigned STAGES  = slr_pkg::FRONT_STAGES;
  localparam int unsigned CNT_W   = $clog2(slr_pkg::QUEUE_DEPTH + 1);

  // ---- helpers -------------------------------------------------------------
  function automatic logic signed [PROD_W-1:0] scale(
    input logic signed [FW-1:0]            c,
    input logic [slr_pkg::ZOOM_W-1:0]      z
  );
    return c * $signed({1'b0, z});
  endfunction

  // divide by 2^12 rounding toward zero
  function automatic logic signed [TRUNC_W-1:0] trunc_frac(
    input logic signed [PROD_W-1:0] p
  );
    logic [PROD_W-1:0] b;
    b = p + (p[PROD_W-1] ? PROD_W'({FB{1'b1}}) : PROD_W'(0));
    return b[PROD_W-1:FB];
  endfunction

  function automatic logic signed [W-1:0] saturate(
    input logic signed [TRUNC_W-1:0] t,
    input logic signed [FW-1:0]      sh
  );
    logic signed [SUM_W-1:0] s, hi, lo;
    s  = SUM_W'(t) + SUM_W'(sh);
    hi = {{(SUM_W-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = ~hi;
    if (s > hi)      return hi[W-1:0];
    else if (s < lo) return lo[W-1:0];
    else             return s[W-1:0];
  endfunction

  // ---- credit --------------------------------------------------------------
  logic             acc;
  logic [CNT_W-1:0] inflight_q, inflight_d;

  assign in_ready_o = (inflight_q < CNT_W'(slr_pkg::QUEUE_DEPTH));
  assign acc        = in_valid_i & in_ready_o;
  assign inflight_d = inflight_q + CNT_W'(acc) - CNT_W'(pop_i);

  // ---- pipeline registers --------------------------------------------------
  logic [STAGES-1:0]           vld_q;
  logic [STAGES-1:0]           act_q;
  logic [slr_pkg::COLOR_W-1:0] col_q [STAGES];

  // index 0 from_x, 1 from_y, 2 to_x, 3 to_y
  logic signed [PROD_W-1:0]  p_s1_q [4];
  logic signed [TRUNC_W-1:0] t_s2_q [4];
  logic signed [W-1:0]       c_s3_q [4];

  logic signed [W-1:0] x0_s4_q, y0_s4_q;
  logic [W:0]          maj_s4_q, min_s4_q;
  logic                mx_s4_q, sd_s4_q;

  logic signed [W-1:0]     x0_s5_q, y0_s5_q;
  logic [W:0]              maj_s5_q;
  logic                    mx_s5_q, sd_s5_q, draw_s5_q;
  logic signed [ERR_W-1:0] err0_s5_q, incp_s5_q, incn_s5_q;

  // ---- stage 4 geometry ----------------------------------------------------
  logic signed [W:0]   dx, dy;
  logic [W:0]          adx, ady, dmaj, dmin;
  logic                mx, swap, sd;
  logic signed [W-1:0] x0_o4, y0_o4;

  always_comb begin
    dx    = {c_s3_q[2][W-1], c_s3_q[2]} - {c_s3_q[0][W-1], c_s3_q[0]};
    dy    = {c_s3_q[3][W-1], c_s3_q[3]} - {c_s3_q[1][W-1], c_s3_q[1]};
    adx   = dx[W] ? (~dx + 1'b1) : dx;
    ady   = dy[W] ? (~dy + 1'b1) : dy;
    mx    = (adx > ady);   // ties go to y
    swap  = mx ? dx[W] : dy[W];
    dmaj  = mx ? adx : ady;
    dmin  = mx ? ady : adx;
    // minor direction after ordering along the major axis
    sd    = (dmin != '0) && (dx[W] ^ dy[W]);
    x0_o4 = swap ? c_s3_q[2] : c_s3_q[0];
    y0_o4 = swap ? c_s3_q[3] : c_s3_q[1];
  end

  // ---- stage 5 set-up terms ------------------------------------------------
  logic [ERR_W-1:0] two_min, one_maj, two_maj;

  always_comb begin
    two_min = {1'b0, min_s4_q, 1'b0};
    one_maj = {2'b00, maj_s4_q};
    two_maj = {1'b0, maj_s4_q, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      inflight_q <= '0;
    end else begin
      vld_q      <= {vld_q[STAGES-2:0], acc};
      inflight_q <= inflight_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= {act_q[STAGES-2:0], in_action_i};
    col_q[0] <= in_color_i;
    for (int i = 1; i < STAGES; i++) begin
      col_q[i] <= col_q[i-1];
    end

    p_s1_q[0] <= scale(in_from_x_i, cfg_i.zoom);
    p_s1_q[1] <= scale(in_from_y_i, cfg_i.zoom);
    p_s1_q[2] <= scale(in_to_x_i,   cfg_i.zoom);
    p_s1_q[3] <= scale(in_to_y_i,   cfg_i.zoom);

    for (int i = 0; i < 4; i++) begin
      t_s2_q[i] <= trunc_frac(p_s1_q[i]);
    end

    c_s3_q[0] <= saturate(t_s2_q[0], cfg_i.shift_x);
    c_s3_q[1] <= saturate(t_s2_q[1], cfg_i.shift_y);
    c_s3_q[2] <= saturate(t_s2_q[2], cfg_i.shift_x);
    c_s3_q[3] <= saturate(t_s2_q[3], cfg_i.shift_y);

    x0_s4_q  <= x0_o4;
    y0_s4_q  <= y0_o4;
    maj_s4_q <= dmaj;
    min_s4_q <= dmin;
    mx_s4_q  <= mx;
    sd_s4_q  <= sd;

    x0_s5_q   <= x0_s4_q;
    y0_s5_q   <= y0_s4_q;
    maj_s5_q  <= maj_s4_q;
    mx_s5_q   <= mx_s4_q;
    sd_s5_q   <= sd_s4_q;
    draw_s5_q <= (maj_s4_q != '0);
    err0_s5_q <= two_min - one_maj;
    incp_s5_q <= two_min - two_maj;
    incn_s5_q <= two_min;
  end

  assign push_o         = vld_q[STAGES-1];
  assign ctl_o.is_start = (slr_pkg::action_e'(act_q[STAGES-1]) == slr_pkg::ACT_START);
  assign ctl_o.drawable   = draw_s5_q;
  assign ctl_o.major_is_x = mx_s5_q;
  assign ctl_o.step_down  = sd_s5_q;
  assign x0_o           = x0_s5_q;
  assign y0_o           = y0_s5_q;
  assign major_delta_o  = maj_s5_q;
  assign err0_o         = err0_s5_q;
  assign inc_pos_o      = incp_s5_q;
  assign inc_neg_o      = incn_s5_q;
  assign color_o        = col_q[STAGES-1];

endmodule

// ----- sv/slr_back.sv -----
// ----------------------------------------------------------------------------
// slr_back: Bresenham walker
// Holds the active line, takes one queued item per cycle while the output
// register is empty or being taken, and emits at most one pixel into it.
// ----------------------------------------------------------------------------
module slr_back #(
  parameter int unsigned COORD_BITS = slr_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  slr_pkg::item_ctl_t                  q_ctl_i,
  input  logic signed [COORD_BITS-1:0]        q_x0_i,
  input  logic signed [COORD_BITS-1:0]        q_y0_i,
  input  logic [COORD_BITS:0]                 q_major_delta_i,
  input  logic signed [COORD_BITS+2:0]        q_err0_i,
  input  logic signed [COORD_BITS+2:0]        q_inc_pos_i,
  input  logic signed [COORD_BITS+2:0]        q_inc_neg_i,
  input  logic [slr_pkg::COLOR_W-1:0]         q_color_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [slr_pkg::FIELD_W-1:0]         out_x_o,
  output logic [slr_pkg::FIELD_W-1:0]         out_y_o,
  output logic [slr_pkg::COLOR_W-1:0]         out_color_o,
  output logic                                out_last_o
);

  localparam int unsigned W     = COORD_BITS;
  localparam int unsigned ERR_W = W + 3;
  localparam int unsigned FW    = slr_pkg::FIELD_W;

  // walker state
  logic                        active_q, active_d;
  logic signed [W-1:0]         cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [ERR_W-1:0]     err_q, err_d, incp_q, incp_d, incn_q, incn_d;
  logic                        mx_q, mx_d, sd_q, sd_d;
  logic [W:0]                  left_q, left_d;
  logic [slr_pkg::COLOR_W-1:0] color_q, color_d;

  // output register
  logic                        ov_q, ov_d;
  logic [FW-1:0]               ox_q, ox_d, oy_q, oy_d;
  logic [slr_pkg::COLOR_W-1:0] oc_q, oc_d;
  logic                        ol_q, ol_d;

  // step sources and results
  logic                    src_start;
  logic signed [W-1:0]     sx, sy, nx, ny, maj_c, min_c, maj_n, min_n;
  logic signed [ERR_W-1:0] se, sp, sn, ne;
  logic                    smx, ssd;

  assign q_pop_o   = q_valid_i & (~ov_q | out_ready_i);
  assign src_start = q_ctl_i.is_start;

  // one Bresenham step from either the new line or the running one
  always_comb begin
    sx    = src_start ? q_x0_i            : cur_x_q;
    sy    = src_start ? q_y0_i            : cur_y_q;
    se    = src_start ? q_err0_i          : err_q;
    sp    = src_start ? q_inc_pos_i       : incp_q;
    sn    = src_start ? q_inc_neg_i       : incn_q;
    smx   = src_start ? q_ctl_i.major_is_x : mx_q;
    ssd   = src_start ? q_ctl_i.step_down  : sd_q;
    maj_c = smx ? sx : sy;
    min_c = smx ? sy : sx;
    maj_n = maj_c + 1'b1;
    if (!se[ERR_W-1]) begin
      min_n = ssd ? (min_c - 1'b1) : (min_c + 1'b1);
      ne    = se + sp;
    end else begin
      min_n = min_c;
      ne    = se + sn;
    end
    nx = smx ? maj_n : min_n;
    ny = smx ? min_n : maj_n;
  end

  always_comb begin
    active_d = active_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    err_d    = err_q;
    incp_d   = incp_q;
    incn_d   = incn_q;
    mx_d     = mx_q;
    sd_d     = sd_q;
    left_d   = left_q;
    color_d  = color_q;
    ov_d     = ov_q & ~out_ready_i;
    ox_d     = ox_q;
    oy_d     = oy_q;
    oc_d     = oc_q;
    ol_d     = ol_q;
    if (q_pop_o) begin
      if (src_start) begin
        active_d = 1'b0;   // any running line is dropped
        if (q_ctl_i.drawable) begin
          ov_d     = 1'b1;
          ox_d     = FW'(q_x0_i);
          oy_d     = FW'(q_y0_i);
          oc_d     = q_color_i;
          ol_d     = 1'b0;
          active_d = 1'b1;
          color_d  = q_color_i;
          mx_d     = q_ctl_i.major_is_x;
          sd_d     = q_ctl_i.step_down;
          incp_d   = q_inc_pos_i;
          incn_d   = q_inc_neg_i;
          left_d   = q_major_delta_i;
          cur_x_d  = nx;
          cur_y_d  = ny;
          err_d    = ne;
        end
      end else if (active_q) begin
        ov_d = 1'b1;
        ox_d = FW'(cur_x_q);
        oy_d = FW'(cur_y_q);
        oc_d = color_q;
        if (left_q == (W+1)'(1)) begin
          ol_d     = 1'b1;
          active_d = 1'b0;
          left_d   = '0;
        end else begin
          ol_d    = 1'b0;
          left_d  = left_q - 1'b1;
          cur_x_d = nx;
          cur_y_d = ny;
          err_d   = ne;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      active_q <= active_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    err_q   <= err_d;
    incp_q  <= incp_d;
    incn_q  <= incn_d;
    mx_q    <= mx_d;
    sd_q    <= sd_d;
    left_q  <= left_d;
    color_q <= color_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    oc_q    <= oc_d;
    ol_q    <= ol_d;
  end

  assign out_valid_o = ov_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_color_o = oc_q;
  assign out_last_o  = ol_q;

endmodule

// ----- sv/slr_checker.sv -----
// ----------------------------------------------------------------------------
// slr_checker: port-level checks for the line rasteriser
// Watches the stream and register ports of the top level; bound below.
// ----------------------------------------------------------------------------
module slr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic [15:0] zoom_q;
  logic        seen_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q    <= slr_pkg::ZOOM_RESET;
      seen_in_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[3:2] == slr_pkg::REG_ZOOM) begin
        zoom_q <= pwdata[15:0];
      end
      if (s_axis_tvalid && s_axis_tready) seen_in_q <= 1'b1;
    end
  end

  // a stalled pixel stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("pixel changed while stalled");

  // zero zoom collapses every line to a point
  a_zero_zoom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> zoom_q != 16'd0)
    else $error("pixel produced with zero zoom");

  a_zoom_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && paddr[3:2] == slr_pkg::REG_ZOOM |-> prdata[15:0] == zoom_q)
    else $error("zoom read back wrong");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> seen_in_q)
    else $error("pixel before any input transfer");

endmodule

bind scaled_line_rasterizer_top slr_checker u_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the scaled line rasteriser
// A queue of start and advance items feeds a stream driver; a local model of
// the projection and Bresenham walk predicts each pixel when its item is
// accepted, and the output monitor checks every pixel transfer against it.
// Register settings change between drained phases over the APB port.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned FIELD_W     = slr_pkg::FIELD_W;
  localparam int unsigned COLOR_W     = slr_pkg::COLOR_W;
  localparam int unsigned ZOOM_W      = slr_pkg::ZOOM_W;
  localparam int unsigned FRAC_BITS   = slr_pkg::FRAC_BITS;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYC  = 20;      // covers pipeline plus queue
  localparam longint      SCR_MAX     = (longint'(1) << (slr_pkg::COORD_BITS_DEF - 1)) - 1;
  localparam longint      SCR_MIN     = -(longint'(1) << (slr_pkg::COORD_BITS_DEF - 1));
  localparam logic [3:0]  ADDR_UNUSED = 4'd12;   // no register behind it

  typedef struct {
    slr_pkg::action_e          act;
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
    logic signed [FIELD_W-1:0] tx;
    logic signed [FIELD_W-1:0] ty;
    logic [COLOR_W-1:0]        color;
  } line_item_t;

  typedef struct {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic [COLOR_W-1:0]        color;
    logic                      last;
  } pixel_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;   // from_x, from_y, to_x, to_y, color
  logic        s_axis_tuser = 1'b0; // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // pixel_x, pixel_y, pixel_color
  logic        m_axis_tlast;        // last_pixel
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  scaled_line_rasterizer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // register copies
  logic [ZOOM_W-1:0]         zoom_q  = slr_pkg::ZOOM_RESET;
  logic signed [FIELD_W-1:0] shx_q   = '0;
  logic signed [FIELD_W-1:0] shy_q   = '0;

  // walker state of the local model
  logic                      line_on;
  logic                      maj_x;
  logic                      step_down;
  logic signed [FIELD_W-1:0] cur_x;
  logic signed [FIELD_W-1:0] cur_y;
  int                        maj_d;
  int                        min_d;
  int                        err_acc;
  int                        px_left;
  logic [COLOR_W-1:0]        line_col;

  line_item_t item_q[$];
  pixel_t     pixel_q[$];
  line_item_t on_bus;
  int         stim_left   = 0;
  int         n_fail      = 0;
  int         pixels_seen = 0;
  int         phase_count = 0;
  int         send_gap    = 0;
  int         recv_gap    = 0;
  int         long_hold   = 0;
  bit         long_done   = 1'b0;
  bit         idle_on     = 1'b1;
  int unsigned cycles     = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // projection: Q12.4 times Q8.8, truncate toward zero, shift, saturate
  function automatic logic signed [FIELD_W-1:0] to_screen(logic signed [FIELD_W-1:0] raw,
                                                          logic signed [FIELD_W-1:0] sh);
    longint prod;
    longint sum;
    prod = longint'(raw) * longint'(zoom_q);
    sum  = prod / (longint'(1) << FRAC_BITS) + longint'(sh);
    if (sum > SCR_MAX) sum = SCR_MAX;
    if (sum < SCR_MIN) sum = SCR_MIN;
    return FIELD_W'(sum);
  endfunction

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int major_len(line_item_t it);
    int dx;
    int dy;
    dx = int'(to_screen(it.tx, shx_q)) - int'(to_screen(it.fx, shx_q));
    dy = int'(to_screen(it.ty, shy_q)) - int'(to_screen(it.fy, shy_q));
    return (iabs(dx) > iabs(dy)) ? iabs(dx) : iabs(dy);
  endfunction

  task automatic push_pixel(logic last);
    pixel_q.push_back('{x: cur_x, y: cur_y, color: line_col, last: last});
  endtask

  task automatic bresenham_step();
    if (err_acc >= 0) begin
      if (maj_x) cur_y = step_down ? cur_y - 16'sd1 : cur_y + 16'sd1;
      else       cur_x = step_down ? cur_x - 16'sd1 : cur_x + 16'sd1;
      err_acc -= 2 * maj_d;
    end
    err_acc += 2 * min_d;
    if (maj_x) cur_x = cur_x + 16'sd1;
    else       cur_y = cur_y + 16'sd1;
  endtask

  task automatic predict_pixel(line_item_t it);
    int x0, y0, x1, y1, dx, dy, t;
    if (it.act == slr_pkg::ACT_START) begin
      x0 = to_screen(it.fx, shx_q);
      y0 = to_screen(it.fy, shy_q);
      x1 = to_screen(it.tx, shx_q);
      y1 = to_screen(it.ty, shy_q);
      line_on = 1'b0;
      maj_x   = iabs(x1 - x0) > iabs(y1 - y0);   // ties go to y
      if (maj_x ? (x0 > x1) : (y0 > y1)) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      maj_d     = maj_x ? dx : dy;
      min_d     = maj_x ? iabs(dy) : iabs(dx);
      step_down = maj_x ? (dy < 0) : (dx < 0);
      if (maj_d == 0) begin
        min_d     = 0;
        step_down = 1'b0;
        return;
      end
      cur_x    = FIELD_W'(x0);
      cur_y    = FIELD_W'(y0);
      line_col = it.color;
      err_acc  = 2 * min_d - maj_d;
      push_pixel(1'b0);
      bresenham_step();
      px_left = maj_d;
      line_on = 1'b1;
    end else if (line_on) begin
      px_left--;
      if (px_left <= 0) begin
        px_left = 0;
        push_pixel(1'b1);
        line_on = 1'b0;
      end else begin
        push_pixel(1'b0);
        bresenham_step();
      end
    end
  endtask

  // stream driver
  always @(posedge clk_i) begin : drv
    logic offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      line_on   = 1'b0;
      maj_x     = 1'b0;
      step_down = 1'b0;
      cur_x     = '0;
      cur_y     = '0;
      maj_d     = 0;
      min_d     = 0;
      err_acc   = 0;
      px_left   = 0;
      line_col  = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pixel(on_bus);
        stim_left--;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        offer = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (item_q.size() > 0) begin
          if (idle_on && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 8);
          end else begin
            on_bus = item_q.pop_front();
            offer  = 1'b1;
          end
        end
        s_axis_tvalid <= offer;
        if (offer) begin
          s_axis_tuser <= on_bus.act;
          s_axis_tdata <= {on_bus.color, on_bus.ty, on_bus.tx, on_bus.fy, on_bus.fx};
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk_i) begin : mon
    pixel_t exp_px;
    logic   rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel: x=%0d y=%0d", $signed(m_axis_tdata[15:0]),
                 $signed(m_axis_tdata[31:16]));
          n_fail++;
        end else begin
          exp_px = pixel_q.pop_front();
          if (m_axis_tdata[15:0] !== exp_px.x) begin
            $error("pixel_x: expected %0d, got %0d", exp_px.x, $signed(m_axis_tdata[15:0]));
            n_fail++;
          end
          if (m_axis_tdata[31:16] !== exp_px.y) begin
            $error("pixel_y: expected %0d, got %0d", exp_px.y, $signed(m_axis_tdata[31:16]));
            n_fail++;
          end
          if (m_axis_tdata[55:32] !== exp_px.color) begin
            $error("pixel_color: expected %06h, got %06h", exp_px.color, m_axis_tdata[55:32]);
            n_fail++;
          end
          if (m_axis_tlast !== exp_px.last) begin
            $error("last_pixel: expected %0b, got %0b", exp_px.last, m_axis_tlast);
            n_fail++;
          end
        end
      end
      rdy = 1'b0;
      if (long_hold > 0) begin
        long_hold--;
      end else if (!long_done && pixels_seen >= 80) begin
        // long hold-off so the block fills up and stalls its input
        long_hold = 300;
        long_done = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 8);
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  task automatic push_item(line_item_t it);
    item_q.push_back(it);
    stim_left++;
  endtask

  function automatic logic signed [FIELD_W-1:0] rand_coord();
    return FIELD_W'($urandom());
  endfunction

  function automatic logic signed [FIELD_W-1:0] near(logic signed [FIELD_W-1:0] c, int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return FIELD_W'(v);
  endfunction

  function automatic line_item_t advance_item();
    line_item_t it;
    it.act   = slr_pkg::ACT_ADVANCE;
    it.fx    = rand_coord();
    it.fy    = rand_coord();
    it.tx    = rand_coord();
    it.ty    = rand_coord();
    it.color = COLOR_W'($urandom());
    return it;
  endfunction

  task automatic push_start(int fx, int fy, int tx, int ty, logic [COLOR_W-1:0] col);
    push_item('{act: slr_pkg::ACT_START, fx: FIELD_W'(fx), fy: FIELD_W'(fy),
                tx: FIELD_W'(tx), ty: FIELD_W'(ty), color: col});
  endtask

  // one line: mostly walked to its end, sometimes cut short or overrun
  task automatic add_line();
    line_item_t it;
    int         span;
    int         len;
    int         n_adv;
    int         k;
    bit         noisy;
    noisy    = ($urandom_range(0, 9) == 0);
    it.act   = slr_pkg::ACT_START;
    it.fx    = rand_coord();
    it.fy    = rand_coord();
    it.color = COLOR_W'($urandom());
    span = (4096 * 24) / ((zoom_q == 0) ? 1 : int'(zoom_q));
    if (span > 32767) span = 32767;
    it.tx = near(it.fx, span);
    it.ty = near(it.fy, span);
    if (noisy) begin
      it.tx = rand_coord();
      it.ty = rand_coord();
    end
    len = major_len(it);
    push_item(it);
    k = $urandom_range(0, 9);
    if (noisy || len > 64) n_adv = $urandom_range(0, 3);
    else if (k == 0)       n_adv = $urandom_range(0, len);
    else if (k == 1)       n_adv = len + $urandom_range(1, 2);
    else                   n_adv = len;
    repeat (n_adv) push_item(advance_item());
    phase_count += 1 + ((n_adv < len) ? n_adv : len);
  endtask

  task automatic run_phase(int n_items);
    phase_count = 0;
    while (phase_count < n_items) add_line();
  endtask

  // stimulus accepted, pixels all in, then let no-result items clear
  task automatic drain();
    while (stim_left != 0) @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check(logic [3:0] addr, logic [15:0] want, string name);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[15:0] !== want) begin
      $error("%s: expected %04h, got %04h", name, want, prdata[15:0]);
      n_fail++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    apb_check({slr_pkg::REG_ZOOM, 2'b00}, zoom_q, "zoom");
    apb_check({slr_pkg::REG_SHIFT_X, 2'b00}, shx_q, "shift_x");
    apb_check({slr_pkg::REG_SHIFT_Y, 2'b00}, shy_q, "shift_y");
  endtask

  task automatic set_config(logic [15:0] zm, logic [15:0] sx, logic [15:0] sy);
    apb_write({slr_pkg::REG_ZOOM, 2'b00}, {16'h0, zm});
    zoom_q = zm;
    apb_write({slr_pkg::REG_SHIFT_X, 2'b00}, {{16{sx[15]}}, sx});
    shx_q = sx;
    apb_write({slr_pkg::REG_SHIFT_Y, 2'b00}, {{16{sy[15]}}, sy});
    shy_q = sy;
    apb_write(ADDR_UNUSED, $urandom());   // must leave the others alone
    check_regs();
  endtask

  initial begin : main
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    // directed lines at unit zoom: 16 raw units map to one pixel
    push_item(advance_item());                          // nothing to advance
    push_start(-15, 5, 15, -7, 24'h123456);             // both truncate onto origin
    push_start(0, 0, 48, 16, 24'h000000);               // x major, three steps
    repeat (3) push_item(advance_item());
    push_start(0, 0, 32, 32, 24'hFFFFFF);               // equal deltas: y major
    repeat (2) push_item(advance_item());
    push_start(32, 0, 0, 32, 24'hA5A5A5);               // minor axis walks down
    repeat (2) push_item(advance_item());
    push_start(-32768, 32767, 32767, -32768, 24'hFFFFFF);
    repeat (2) push_item(advance_item());
    push_start(64, 0, 0, 16, 24'h5A5A5A);               // swapped, abandons previous
    repeat (5) push_item(advance_item());               // last one overruns
    drain();

    run_phase(140);
    drain();
    set_config(16'hFFFF, 16'h7FFF, 16'h8000);
    run_phase(130);
    drain();
    set_config(16'h0000, 16'd100, -16'sd100);           // every start collapses
    run_phase(30);
    drain();
    set_config(16'h0080, 16'h8000, 16'h7FFF);
    run_phase(130);
    drain();
    repeat (2) begin
      set_config(16'($urandom()), 16'($urandom()), 16'($urandom()));
      run_phase(130);
      drain();
    end
    idle_on = 1'b0;
    set_config(slr_pkg::ZOOM_RESET, 16'($urandom_range(0, 400)) - 16'd200,
               16'($urandom_range(0, 400)) - 16'd200);
    run_phase(130);
    drain();

    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/slr_pkg.sv
sv/slr_regs.sv
sv/slr_queue.sv
sv/slr_front.sv
sv/slr_back.sv
sv/scaled_line_rasterizer_top.sv
sv/slr_checker.sv
tb/sv/testbench.sv
